@@ src/wavetable_crossfade_oscillator_unit_defines.svh @@
// Assertion macros used by the oscillator top level.
`ifndef WAVETABLE_CROSSFADE_OSCILLATOR_UNIT_DEFINES_SVH
`define WAVETABLE_CROSSFADE_OSCILLATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define WXO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wxo assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define WXO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wxo assertion failed");

`else

`define WXO_ASSERT_IMP(lbl, ante, cons)
`define WXO_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ src/wxo_pkg.sv @@
// Shared types and constants of the wavetable crossfade oscillator.
`default_nettype none

package wxo_pkg;

  localparam int DEF_TABLE_DEPTH  = 2048;
  localparam int DEF_SAMPLE_WIDTH = 16;

  localparam int FRAC_BITS = 21;
  localparam int STEP_W    = 32;
  localparam int MIXPOS_W  = 16;
  localparam int WGT_W     = 17;
  localparam int AMP_W     = 16;
  localparam int Q15_BITS  = 15;

  localparam logic [WGT_W-1:0] UNITY_Q15 = 17'd32768;
  localparam logic [AMP_W-1:0] AMP_RESET = 16'd3277;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [WGT_W-1:0] saw_w;
    logic [MIXPOS_W-1:0]     sin_w;
    logic [FRAC_BITS-1:0]    frac;
  } fx_weight_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef enum logic [0:0] {
    FR_IDLE,
    FR_REDUCE
  } front_state_t;

endpackage

`default_nettype wire

@@ src/wxo_queue.sv @@
// Small FIFO that decouples the phase front end from the synthesis pipeline.
`default_nettype none

module wxo_queue #(
  parameter int DATA_W = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire logic [DATA_W-1:0]  wdata,
  input  wire logic               pop,
  output logic [DATA_W-1:0]       rdata,
  output wxo_pkg::fifo_status_t   status
);
  import wxo_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  logic [DATA_W-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign rdata        = slot_r[rd_ptr_r];
  assign status.full  = (cnt_r == FULL_CNT);
  assign status.empty = (cnt_r == '0);

endmodule

`default_nettype wire

@@ src/wxo_front.sv @@
// Front end: accepts sample ticks, derives table indexes and weights, advances the phase.
`default_nettype none

module wxo_front #(
  parameter int TABLE_DEPTH = wxo_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [wxo_pkg::STEP_W-1:0]            in_phase_step,
  input  wire logic [wxo_pkg::MIXPOS_W-1:0]          in_mix_position,
  input  wire wxo_pkg::fifo_status_t                 q_status,
  output logic                                       q_push,
  output logic [$clog2(TABLE_DEPTH)-1:0]             q_idx,
  output logic [$clog2(TABLE_DEPTH)-1:0]             q_idx_up,
  output wxo_pkg::fx_weight_t                        q_wgt
);
  import wxo_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int ACC_W = IDX_W + FRAC_BITS;
  localparam int SUM_W = ((ACC_W > STEP_W) ? ACC_W : STEP_W) + 1;
  localparam int RED_K = SUM_W - ACC_W;
  localparam int DIV_W = SUM_W + 1;
  localparam int CNT_W = $clog2(RED_K + 1);

  localparam logic [DIV_W-1:0] DIV_INIT = DIV_W'(TABLE_DEPTH) << (FRAC_BITS + RED_K);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(RED_K);

  front_state_t state_r, state_nxt;

  logic [ACC_W-1:0] phase_r, phase_nxt;
  logic [SUM_W-1:0] rem_r, rem_nxt, rem_sub;
  logic [DIV_W-1:0] div_r, div_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic [IDX_W-1:0] idx;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FR_IDLE: begin
        if (accept) begin
          state_nxt = FR_REDUCE;
        end
      end
      FR_REDUCE: begin
        if (cnt_r == '0) begin
          state_nxt = FR_IDLE;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall = 1'b1;
    unique case (state_r)
      FR_IDLE:   in_stall = q_status.full;
      FR_REDUCE: in_stall = 1'b1;
      default:   in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;
  assign q_push = accept;

  // Table lookup positions and crossfade weights for the current phase.
  assign idx         = phase_r[ACC_W-1:FRAC_BITS];
  assign q_idx       = idx;
  assign q_idx_up    = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
  assign q_wgt.frac  = phase_r[FRAC_BITS-1:0];
  assign q_wgt.sin_w = in_mix_position;
  assign q_wgt.saw_w = $signed(UNITY_Q15 - {1'b0, in_mix_position});

  // Restoring reduction of phase + step modulo the table span, one divisor shift per cycle.
  assign rem_sub = ({1'b0, rem_r} >= div_r) ? rem_r - div_r[SUM_W-1:0] : rem_r;

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    if (state_r == FR_IDLE) begin
      if (accept) begin
        rem_nxt = SUM_W'(phase_r) + SUM_W'(in_phase_step);
        div_nxt = DIV_INIT;
        cnt_nxt = CNT_INIT;
      end
    end else begin
      rem_nxt = rem_sub;
      div_nxt = div_r >> 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        phase_nxt = rem_sub[ACC_W-1:0];
        cnt_nxt   = cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
      phase_r <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

endmodule

`default_nettype wire

@@ src/wxo_back.sv @@
// Back end: table reads, interpolation, crossfade, gain and saturation pipeline.
`default_nettype none

module wxo_back #(
  parameter int TABLE_DEPTH  = wxo_pkg::DEF_TABLE_DEPTH,
  parameter int SAMPLE_WIDTH = wxo_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [wxo_pkg::AMP_W-1:0]         cfg_wr_data,
  input  wire wxo_pkg::fifo_status_t             q_status,
  output logic                                   q_pop,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]    q_idx,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]    q_idx_up,
  input  wire wxo_pkg::fx_weight_t               q_wgt,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]         out_sample
);
  import wxo_pkg::*;

  localparam int SW        = SAMPLE_WIDTH;
  localparam int IP_W      = SW + FRAC_BITS + 2;
  localparam int WP_W      = IP_W + WGT_W;
  localparam int WS_W      = WP_W + 1;
  localparam int MIX_W     = WS_W - FRAC_BITS;
  localparam int SC_W      = MIX_W + AMP_W + 1;
  localparam int AMP_SHIFT = 2 * Q15_BITS;
  localparam int NSTG      = 6;

  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam longint          DEPTH_L    = longint'(TABLE_DEPTH);

  localparam logic signed [WS_W-1:0] RND_MIX = WS_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SC_W-1:0] RND_OUT = SC_W'(1) <<< (AMP_SHIFT - 1);
  localparam logic signed [SC_W-1:0] SAT_HI  = (SC_W'(1) <<< (SW - 1)) - SC_W'(1);
  localparam logic signed [SC_W-1:0] SAT_LO  = -(SC_W'(1) <<< (SW - 1));

  typedef logic signed [SAMPLE_WIDTH-1:0] rom_t [TABLE_DEPTH];

  // Sine of r / 2^32 turns for a quarter wave, Q30, odd Taylor terms up to x^11.
  function automatic longint quarter_sine(longint unsigned r);
    longint unsigned x, x2, term;
    longint sum;
    x    = (r * TWO_PI_Q30) >> 32;
    x2   = (x * x) >> 30;
    sum  = longint'(x);
    term = ((x * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) <<< 30)) begin
      sum = longint'(1) <<< 30;
    end
    return sum;
  endfunction

  function automatic rom_t build_sine();
    rom_t t;
    longint unsigned p, r;
    longint s, mag, smax;
    int unsigned quad;
    int i;
    smax = (longint'(1) <<< (SW - 1)) - 1;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      p    = (longint'(i) << 32) / DEPTH_L;
      quad = int'((p >> 30) & 3);
      r    = p & ((longint'(1) << 30) - 1);
      if (quad[0]) begin
        r = (longint'(1) << 30) - r;
      end
      s    = quarter_sine(r);
      mag  = (s * smax + (longint'(1) <<< 29)) >>> 30;
      t[i] = SW'((quad >= 2) ? -mag : mag);
    end
    return t;
  endfunction

  // Ramp in thousandths of full scale, wrapping from just below one to minus one.
  function automatic rom_t build_saw();
    rom_t t;
    longint k, full;
    int i;
    full = longint'(1) <<< (SW - 1);
    k    = 0;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      t[i] = SW'((((k + 1000) * full + 500) / 1000) - full);
      k    = k + 1;
      if (k >= 1000) begin
        k = k - 2000;
      end
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_sine();
  localparam rom_t SAW_ROM  = build_saw();

  logic [AMP_W-1:0] amp_r;
  logic             adv;
  logic [NSTG-1:0]  vld_r;
  logic             out_valid_r;

  // Stage 1: table words.
  logic signed [SW-1:0]       s1_saw0_r, s1_saw1_r, s1_sin0_r, s1_sin1_r;
  logic [FRAC_BITS-1:0]       s1_frac_r;
  logic signed [WGT_W-1:0]    s1_saw_w_r;
  logic [MIXPOS_W-1:0]        s1_sin_w_r;
  // Stage 2: slope times fraction.
  logic signed [SW:0]         saw_d, sin_d;
  logic signed [FRAC_BITS:0]  frac_s;
  logic signed [IP_W-1:0]     psaw_nxt, psin_nxt, s2_psaw_r, s2_psin_r;
  logic signed [SW-1:0]       s2_saw0_r, s2_sin0_r;
  logic signed [WGT_W-1:0]    s2_saw_w_r;
  logic [MIXPOS_W-1:0]        s2_sin_w_r;
  // Stage 3: interpolated values.
  logic signed [IP_W-1:0]     sawi_nxt, sini_nxt, s3_sawi_r, s3_sini_r;
  logic signed [WGT_W-1:0]    s3_saw_w_r;
  logic [MIXPOS_W-1:0]        s3_sin_w_r;
  // Stage 4: weighted terms.
  logic signed [WP_W-1:0]     ws_nxt, wn_nxt, s4_ws_r, s4_wn_r;
  // Stage 5: crossfade in sample units of 2^-15.
  logic signed [WS_W-1:0]     wsum;
  logic signed [MIX_W-1:0]    mix_nxt, s5_mix_r;
  // Stage 6: gain applied.
  logic signed [SC_W-1:0]     scaled_nxt, s6_scaled_r;
  // Output register.
  logic signed [SC_W-1:0]     rnd_sum, shifted, clamped;
  logic signed [SW-1:0]       out_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r <= AMP_RESET;
    end else if (cfg_wr_en) begin
      amp_r <= cfg_wr_data;
    end
  end

  // The whole pipeline moves together whenever the output register can take a beat.
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_status.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-2:0], !q_status.empty};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  assign saw_d  = {s1_saw1_r[SW-1], s1_saw1_r} - {s1_saw0_r[SW-1], s1_saw0_r};
  assign sin_d  = {s1_sin1_r[SW-1], s1_sin1_r} - {s1_sin0_r[SW-1], s1_sin0_r};
  assign frac_s = $signed({1'b0, s1_frac_r});

  always_comb begin
    psaw_nxt   = IP_W'(saw_d) * IP_W'(frac_s);
    psin_nxt   = IP_W'(sin_d) * IP_W'(frac_s);
    sawi_nxt   = (IP_W'(s2_saw0_r) <<< FRAC_BITS) + s2_psaw_r;
    sini_nxt   = (IP_W'(s2_sin0_r) <<< FRAC_BITS) + s2_psin_r;
    ws_nxt     = WP_W'(s3_sawi_r) * WP_W'(s3_saw_w_r);
    wn_nxt     = WP_W'(s3_sini_r) * WP_W'($signed({1'b0, s3_sin_w_r}));
    wsum       = WS_W'(s4_ws_r) + WS_W'(s4_wn_r) + RND_MIX;
    mix_nxt    = MIX_W'(wsum >>> FRAC_BITS);
    scaled_nxt = SC_W'(s5_mix_r) * SC_W'($signed({1'b0, amp_r}));
    rnd_sum    = s6_scaled_r + RND_OUT;
    shifted    = rnd_sum >>> AMP_SHIFT;
    if (shifted > SAT_HI) begin
      clamped = SAT_HI;
    end else if (shifted < SAT_LO) begin
      clamped = SAT_LO;
    end else begin
      clamped = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_saw0_r    <= SAW_ROM[q_idx];
      s1_saw1_r    <= SAW_ROM[q_idx_up];
      s1_sin0_r    <= SINE_ROM[q_idx];
      s1_sin1_r    <= SINE_ROM[q_idx_up];
      s1_frac_r    <= q_wgt.frac;
      s1_saw_w_r   <= q_wgt.saw_w;
      s1_sin_w_r   <= q_wgt.sin_w;

      s2_psaw_r    <= psaw_nxt;
      s2_psin_r    <= psin_nxt;
      s2_saw0_r    <= s1_saw0_r;
      s2_sin0_r    <= s1_sin0_r;
      s2_saw_w_r   <= s1_saw_w_r;
      s2_sin_w_r   <= s1_sin_w_r;

      s3_sawi_r    <= sawi_nxt;
      s3_sini_r    <= sini_nxt;
      s3_saw_w_r   <= s2_saw_w_r;
      s3_sin_w_r   <= s2_sin_w_r;

      s4_ws_r      <= ws_nxt;
      s4_wn_r      <= wn_nxt;
      s5_mix_r     <= mix_nxt;
      s6_scaled_r  <= scaled_nxt;
      out_sample_r <= clamped[SW-1:0];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

`default_nettype wire

@@ src/wavetable_crossfade_oscillator_unit.sv @@
// Top level of the wavetable crossfade oscillator: phase front end, FIFO, synthesis pipeline.
// An accepted beat goes through the FIFO, the pipeline stages and the output register to out_valid.
// The front end takes a new beat only once its modulo reduction of the phase is done,
//   one compare-subtract a cycle.
// Reset (synchronous, rst_n low): phase to zero, FIFO and pipeline emptied, gain to 3277.
// The sine and saw tables are constant ROMs and need no fill or clearing pass.
`default_nettype none
`include "wavetable_crossfade_oscillator_unit_defines.svh"

module wavetable_crossfade_oscillator_unit #(
  parameter int TABLE_DEPTH  = wxo_pkg::DEF_TABLE_DEPTH,
  parameter int SAMPLE_WIDTH = wxo_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Gain register, unsigned Q1.15.
  input  wire logic                              cfg_wr_en,
  input  wire logic [wxo_pkg::AMP_W-1:0]         cfg_wr_data,
  // Sample ticks.
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [wxo_pkg::STEP_W-1:0]        in_phase_step,
  input  wire logic [wxo_pkg::MIXPOS_W-1:0]      in_mix_position,
  // Output samples.
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]         out_sample
);
  import wxo_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int Q_W   = 2 * IDX_W + $bits(fx_weight_t);

  // The front end owns the phase accumulator. Each accepted beat uses the phase as it stands,
  // splits it into a table index (with its wrapped upper neighbor) and a 21-bit fraction, and
  // turns the mix position into the saw and sine weights. That packet goes into the FIFO in the
  // same cycle; the front end then brings phase + step back into range and stalls until done.
  logic [IDX_W-1:0] f_idx, f_idx_up;
  fx_weight_t       f_wgt;
  logic             q_push, q_pop;
  logic [Q_W-1:0]   q_wdata, q_rdata;
  fifo_status_t     q_stat;

  // The back end drains the FIFO into a six-stage pipeline: table reads, slope times fraction,
  // interpolated sums, weighted terms, rounded crossfade, gain, then round and saturate into the
  // output register. All stages advance together whenever the output register is free, so a
  // stalled sink simply holds the pipeline while the front end keeps filling the FIFO.
  logic [IDX_W-1:0] b_idx, b_idx_up;
  fx_weight_t       b_wgt;

  wxo_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_phase_step   (in_phase_step),
    .in_mix_position (in_mix_position),
    .q_status        (q_stat),
    .q_push          (q_push),
    .q_idx           (f_idx),
    .q_idx_up        (f_idx_up),
    .q_wgt           (f_wgt)
  );

  assign q_wdata = {f_idx, f_idx_up, f_wgt};

  wxo_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_stat)
  );

  assign {b_idx, b_idx_up, b_wgt} = q_rdata;

  wxo_back #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_status    (q_stat),
    .q_pop       (q_pop),
    .q_idx       (b_idx),
    .q_idx_up    (b_idx_up),
    .q_wgt       (b_wgt),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_sample  (out_sample)
  );

  // The front end never writes a full FIFO, and the back end never reads an empty one.
  `WXO_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full)
  `WXO_ASSERT_IMP(a_no_pop_empty, q_pop, !q_stat.empty)
  // In the cycle after a beat is taken the front end must be stalled, busy reducing the phase.
  `WXO_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

`default_nettype wire
